>>> sv/ott_pkg.sv
package ott_pkg;

  // Width of the internal byte position and token start registers.
  localparam int OFFSET_BITS = 32;

  // Most tokens that a single byte can cause.
  localparam int MAX_RESULTS = 3;
  localparam int COUNT_BITS  = $clog2(MAX_RESULTS + 1);

  // Token kinds as delivered on the output channel.
  typedef enum logic [2:0] {
    KIND_END   = 3'd0,
    KIND_SLASH = 3'd1,
    KIND_WORD  = 3'd2,
    KIND_INT   = 3'd3,
    KIND_REAL  = 3'd4,
    KIND_STOP  = 3'd5
  } kind_t;

  // One byte of the input stream.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       stream_end;
  } in_item_t;

  // One token on the output channel.
  typedef struct packed {
    kind_t       token_kind;
    logic [31:0] token_offset;
    logic [31:0] token_length;
    logic        last_result;
  } out_item_t;

  // All tokens caused by one byte, packed from slot 0 upwards.
  typedef struct packed {
    logic [COUNT_BITS-1:0]        count;
    out_item_t [MAX_RESULTS-1:0]  slot;
  } bundle_t;

  // Status of the output stage as seen by the input side.
  typedef struct packed {
    logic                  full;
    logic [COUNT_BITS-1:0] pending;
  } ser_status_t;

endpackage

>>> sv/obj_text_tokenizer.sv
// Streaming OBJ-style text tokenizer. One byte is accepted per cycle on the
// byte channel while byte_stall is low, and its tokens appear on the token
// channel from the next cycle on. A byte causes zero to three tokens (slash,
// word, integer, real, stop, end), and the last token of each byte carries
// last_result. The single result register releases one token per cycle unless
// token_stall holds it; the next byte is taken in the cycle that the final
// token of the previous one leaves, and bytes causing at most one token stream
// at one per cycle unless stalled. After a stop token the rest of the stream
// yields nothing; a byte flagged stream_end restarts offsets at zero.
module obj_text_tokenizer (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  ott_pkg::in_item_t  byte_data,
  output logic               token_valid,
  input  logic               token_stall,
  output ott_pkg::out_item_t token_data
);
  import ott_pkg::*;

  bundle_t     bundle;
  ser_status_t status;
  logic        load;

  assign byte_stall = status.full;
  assign load       = byte_valid && !byte_stall;

  // Phase tracking and token generation.
  ott_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .item   (byte_data),
    .bundle (bundle)
  );

  // Result register and token sequencing.
  ott_serial u_serial (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .bundle      (bundle),
    .token_stall (token_stall),
    .token_valid (token_valid),
    .token_data  (token_data),
    .status      (status)
  );

  // A byte is only taken when at most one earlier token is still waiting.
  a_accept_room: assert property (@(posedge clk) disable iff (rst)
    load |-> (status.pending <= COUNT_BITS'(1)))
    else $error("byte accepted while several tokens were still waiting");

  // Tokens of one byte follow without a gap in token_valid until the one marked last.
  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    (token_valid && !token_stall && !token_data.last_result) |=> token_valid)
    else $error("token burst broken before its last transaction");

  // End and stop tokens carry no text.
  a_empty_marks: assert property (@(posedge clk) disable iff (rst)
    (token_valid && (token_data.token_kind == KIND_END || token_data.token_kind == KIND_STOP))
      |-> (token_data.token_length == 32'd0))
    else $error("end or stop token with non-zero length");

endmodule

>>> sv/ott_scan.sv
module ott_scan (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  ott_pkg::in_item_t item,
  output ott_pkg::bundle_t  bundle
);
  import ott_pkg::*;

  typedef enum logic [2:0] {
    PH_BETWEEN = 3'd0,
    PH_COMMENT = 3'd1,
    PH_WORD    = 3'd2,
    PH_NUMBER  = 3'd3,
    PH_STOPPED = 3'd4
  } phase_t;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

  function automatic logic is_white(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  // Cut a position or length to the 32 bits of the output fields.
  function automatic logic [31:0] to_out(input logic [OFFSET_BITS:0] v);
    logic [64:0] w;
    w = 65'(v);
    return w[31:0];
  endfunction

  function automatic out_item_t make(input kind_t k, input logic [OFFSET_BITS:0] off,
                                     input logic [OFFSET_BITS:0] len);
    out_item_t r;
    r.token_kind   = k;
    r.token_offset = to_out(off);
    r.token_length = to_out(len);
    r.last_result  = 1'b0;
    return r;
  endfunction

  phase_t                 phase, phase_next;
  logic                   saw_dot, saw_dot_next;
  logic [OFFSET_BITS-1:0] byte_position, byte_position_next;
  logic [OFFSET_BITS-1:0] token_begin, token_begin_next;

  logic [OFFSET_BITS-1:0] pos_inc;
  logic [OFFSET_BITS:0]   run_len;
  logic [OFFSET_BITS:0]   flush_len;
  logic                   between;
  logic [COUNT_BITS-1:0]  n;
  logic [7:0]             b;
  bundle_t                bnd;

  assign b       = item.text_byte;
  assign pos_inc = (byte_position == POS_MAX) ? byte_position : byte_position + 1'b1;
  assign run_len = {1'b0, byte_position} - {1'b0, token_begin};

  // Phase update and token generation for the current byte.
  always_comb begin
    phase_next         = phase;
    saw_dot_next       = saw_dot;
    token_begin_next   = token_begin;
    byte_position_next = pos_inc;
    between            = 1'b0;
    n                  = '0;
    bnd                = '0;
    flush_len          = '0;

    // Continue or close the token in progress.
    case (phase)
      PH_STOPPED: begin
      end
      PH_COMMENT: begin
        if (b == CH_NL) phase_next = PH_BETWEEN;
      end
      PH_WORD: begin
        if (!is_alpha(b)) begin
          bnd.slot[n] = make(KIND_WORD, {1'b0, token_begin}, run_len);
          n = n + 1'b1;
          phase_next = PH_BETWEEN;
          between = 1'b1;
        end
      end
      PH_NUMBER: begin
        if (is_white(b) || b == CH_SLASH) begin
          bnd.slot[n] = make(saw_dot ? KIND_REAL : KIND_INT, {1'b0, token_begin}, run_len);
          n = n + 1'b1;
          phase_next = PH_BETWEEN;
          between = 1'b1;
        end else if (b == CH_DOT) begin
          saw_dot_next = 1'b1;
        end
      end
      default: begin
        phase_next = PH_BETWEEN;
        between = 1'b1;
      end
    endcase

    // The byte seen as if it came between tokens.
    if (between) begin
      if (is_white(b)) begin
      end else if (b == CH_HASH) begin
        phase_next = PH_COMMENT;
      end else if (b == CH_SLASH) begin
        bnd.slot[n] = make(KIND_SLASH, {1'b0, byte_position}, (OFFSET_BITS+1)'(1));
        n = n + 1'b1;
      end else if (is_alpha(b)) begin
        phase_next = PH_WORD;
        token_begin_next = byte_position;
      end else if (is_digit(b) || b == CH_MINUS) begin
        phase_next = PH_NUMBER;
        token_begin_next = byte_position;
        saw_dot_next = 1'b0;
      end else begin
        bnd.slot[n] = make(KIND_STOP, {1'b0, byte_position}, '0);
        n = n + 1'b1;
        phase_next = PH_STOPPED;
      end
    end

    // End of stream: flush the pending token, add the end token and restart.
    if (item.stream_end) begin
      flush_len = ({1'b0, byte_position} - {1'b0, token_begin_next}) + 1'b1;
      if (phase_next == PH_WORD) begin
        bnd.slot[n] = make(KIND_WORD, {1'b0, token_begin_next}, flush_len);
        n = n + 1'b1;
      end else if (phase_next == PH_NUMBER) begin
        bnd.slot[n] = make(saw_dot_next ? KIND_REAL : KIND_INT, {1'b0, token_begin_next},
                           flush_len);
        n = n + 1'b1;
      end
      if (phase_next != PH_STOPPED) begin
        bnd.slot[n] = make(KIND_END, {1'b0, pos_inc}, '0);
        n = n + 1'b1;
      end
      phase_next         = PH_BETWEEN;
      saw_dot_next       = 1'b0;
      byte_position_next = '0;
      token_begin_next   = '0;
    end

    // Mark the final token of this byte.
    for (int i = 0; i < MAX_RESULTS; i++) begin
      bnd.slot[i].last_result = (n == COUNT_BITS'(i + 1));
    end
    bnd.count = n;
  end

  assign bundle = bnd;

  // Scanner state, advanced once per accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_BETWEEN;
      saw_dot       <= 1'b0;
      byte_position <= '0;
      token_begin   <= '0;
    end else if (load) begin
      phase         <= phase_next;
      saw_dot       <= saw_dot_next;
      byte_position <= byte_position_next;
      token_begin   <= token_begin_next;
    end
  end

endmodule

>>> sv/ott_serial.sv
module ott_serial (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  ott_pkg::bundle_t     bundle,
  input  logic                 token_stall,
  output logic                 token_valid,
  output ott_pkg::out_item_t   token_data,
  output ott_pkg::ser_status_t status
);
  import ott_pkg::*;

  logic [COUNT_BITS-1:0]       count;
  out_item_t [MAX_RESULTS-1:0] slot;
  logic                        take;

  assign token_valid = (count != '0);
  assign token_data  = slot[0];
  assign take        = token_valid && !token_stall;

  // A new bundle may enter once at most the last waiting token leaves this cycle.
  assign status.full    = (count > COUNT_BITS'(1)) || ((count == COUNT_BITS'(1)) && token_stall);
  assign status.pending = count;

  // Result register: loaded with a whole bundle, shifted down as tokens leave.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= bundle.count;
    end else if (take) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= bundle.slot;
    end else if (take) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        slot[i] <= slot[i + 1];
      end
    end
  end

endmodule
